/* hw/rtl/orf_pkg.sv */
// Package for the outlier-rejecting ADC filter: shared widths, controller
// states and the controller/datapath command and status structs.
// No dependencies.
package orf_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned Burst = 8;
  localparam int unsigned BurstShift = 3;
  localparam int unsigned SumW = 15;
  localparam int unsigned SqW = 27;
  localparam int unsigned RootW = SqW + 2;
  localparam int unsigned StoreW = 14;
  localparam int unsigned AxisW = 2;
  localparam int unsigned CntW = 4;
  localparam logic [StoreW-1:0] SmoothReset = 14'd2048;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_CLIP,
    ST_DIV,
    ST_SMOOTH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic sqrt_init;
    logic sqrt_step;
    logic clip;
    logic div_init;
    logic div_step;
    logic smooth;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
    logic sqrt_done;
    logic div_done;
  } status_t;

endpackage

/* hw/rtl/orf_ctrl.sv */
// Controller state machine of the outlier-rejecting ADC filter.
// Depends on orf_pkg.
module orf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  orf_pkg::status_t status_i,
  output orf_pkg::cmd_t    cmd_o
);

  orf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      orf_pkg::ST_IDLE:   if (in_valid_i) state_d = orf_pkg::ST_SQ;
      orf_pkg::ST_SQ:     if (status_i.sq_done) state_d = orf_pkg::ST_SQRT;
      orf_pkg::ST_SQRT:   if (status_i.sqrt_done) state_d = orf_pkg::ST_CLIP;
      orf_pkg::ST_CLIP:   state_d = orf_pkg::ST_DIV;
      orf_pkg::ST_DIV:    if (status_i.div_done) state_d = orf_pkg::ST_SMOOTH;
      orf_pkg::ST_SMOOTH: state_d = orf_pkg::ST_OUT;
      orf_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = in_valid_i ? orf_pkg::ST_SQ : orf_pkg::ST_IDLE;
        end
      end
      default:            state_d = orf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      orf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      orf_pkg::ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.sqrt_init = status_i.sq_done;
      end
      orf_pkg::ST_SQRT:   cmd_o.sqrt_step = !status_i.sqrt_done;
      orf_pkg::ST_CLIP: begin
        cmd_o.clip = 1'b1;
      end
      orf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      orf_pkg::ST_SMOOTH: cmd_o.smooth = 1'b1;
      orf_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        in_stall_o = out_stall_i;
        cmd_o.load = in_valid_i && !out_stall_i;
      end
      default: ;
    endcase
    cmd_o.div_init = cmd_o.clip;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !in_stall_o && in_valid_i)
    else $error("load without transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == orf_pkg::ST_SQ)
    else $error("load did not start work");

endmodule

/* hw/rtl/orf_datapath.sv */
// Datapath of the outlier-rejecting ADC filter: sums, squared deviations,
// bit-pair square root, restoring divider and per-axis smoother store.
// Depends on orf_pkg.
module orf_datapath #(
  parameter int unsigned AXES = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  orf_pkg::cmd_t                      cmd_i,
  output orf_pkg::status_t                   status_o,
  input  logic [orf_pkg::AxisW-1:0]          axis_i,
  input  logic [orf_pkg::Burst-1:0][orf_pkg::SampleW-1:0] samples_i,
  output logic [orf_pkg::AxisW-1:0]          axis_out_o,
  output logic [orf_pkg::StoreW-1:0]         smoothed_value_o,
  output logic [orf_pkg::SampleW-1:0]        clipped_mean_o
);

  localparam int unsigned SW = orf_pkg::SampleW;
  localparam int unsigned IdxW = orf_pkg::BurstShift;
  localparam int unsigned SelW = $clog2(AXES > 1 ? AXES : 2);

  logic [orf_pkg::Burst-1:0][SW-1:0] s_q;
  logic [orf_pkg::AxisW-1:0] axis_q;
  logic [SW-1:0] mean_q;
  logic [orf_pkg::SqW-1:0] sq_q, rem_q;
  logic [IdxW-1:0] idx_q;
  logic [orf_pkg::RootW-1:0] root_q, bit_q;
  logic [orf_pkg::SumW-1:0] kept_q, dvd_q;
  logic [orf_pkg::CntW-1:0] cnt_q, dcnt_q;
  logic [SW-1:0] quo_q;
  logic [orf_pkg::StoreW-1:0] smooth_q;
  logic [AXES-1:0][orf_pkg::StoreW-1:0] store_q;

  logic [orf_pkg::SumW-1:0] sum_w;
  logic [SW-1:0] dev_w;
  logic [2*SW-1:0] dsq_w;
  logic [orf_pkg::Burst-1:0] keep_w;
  logic [orf_pkg::SumW-1:0] kept_w;
  logic [orf_pkg::CntW-1:0] cnt_w;
  logic [orf_pkg::RootW-1:0] rtrial_w;
  logic [orf_pkg::StoreW-1:0] old_w;
  logic [orf_pkg::StoreW:0] inc_w;
  logic [orf_pkg::StoreW-1:0] new_w;
  logic [SelW-1:0] sel_w;
  logic axis_ok_w;

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < orf_pkg::Burst; i++) begin
      sum_w = sum_w + orf_pkg::SumW'(samples_i[i]);
    end
  end

  assign dev_w = (s_q[idx_q] >= mean_q) ? s_q[idx_q] - mean_q : mean_q - s_q[idx_q];
  assign dsq_w = dev_w * dev_w;
  assign rtrial_w = root_q + bit_q;

  always_comb begin
    kept_w = '0;
    cnt_w = '0;
    for (int i = 0; i < orf_pkg::Burst; i++) begin
      logic [SW-1:0] d;
      d = (s_q[i] >= mean_q) ? s_q[i] - mean_q : mean_q - s_q[i];
      keep_w[i] = orf_pkg::RootW'(d) <= root_q;
      if (keep_w[i]) begin
        kept_w = kept_w + orf_pkg::SumW'(s_q[i]);
        cnt_w = cnt_w + 1'b1;
      end
    end
  end

  assign axis_ok_w = 32'(axis_q) < AXES;
  assign sel_w = SelW'(axis_q);
  assign old_w = axis_ok_w ? store_q[sel_w] : '0;
  assign inc_w = {1'b0, old_w} + (orf_pkg::StoreW+1)'(2);
  assign new_w = old_w - orf_pkg::StoreW'(inc_w >> 2) + orf_pkg::StoreW'(quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= samples_i;
      axis_q <= axis_i;
      mean_q <= SW'(sum_w >> orf_pkg::BurstShift);
      sq_q <= '0;
      idx_q <= '0;
    end
    if (cmd_i.sq_step) begin
      sq_q <= sq_q + orf_pkg::SqW'(dsq_w);
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.sqrt_init) begin
      rem_q <= sq_q + orf_pkg::SqW'(dsq_w);
      root_q <= '0;
      bit_q <= orf_pkg::RootW'(1) << 26;
    end
    if (cmd_i.sqrt_step) begin
      if (orf_pkg::RootW'(rem_q) >= rtrial_w) begin
        rem_q <= orf_pkg::SqW'(orf_pkg::RootW'(rem_q) - rtrial_w);
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      kept_q <= kept_w;
      cnt_q <= cnt_w;
      dcnt_q <= orf_pkg::CntW'(orf_pkg::SumW - 1);
      dvd_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if ({dvd_q[orf_pkg::SumW-2:0], kept_q[dcnt_q]} >= orf_pkg::SumW'(cnt_q)) begin
        dvd_q <= {dvd_q[orf_pkg::SumW-2:0], kept_q[dcnt_q]} - orf_pkg::SumW'(cnt_q);
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        dvd_q <= {dvd_q[orf_pkg::SumW-2:0], kept_q[dcnt_q]};
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.smooth) begin
      smooth_q <= axis_ok_w ? new_w : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= {AXES{orf_pkg::SmoothReset}};
    end else if (cmd_i.smooth && axis_ok_w) begin
      store_q[sel_w] <= new_w;
    end
  end

  assign status_o.sq_done = idx_q == '1;
  assign status_o.sqrt_done = bit_q == '0;
  assign status_o.div_done = dcnt_q == '0;
  assign axis_out_o = axis_q;
  assign smoothed_value_o = smooth_q;
  assign clipped_mean_o = quo_q;

endmodule

/* hw/rtl/outlier_rejecting_adc_filter.sv */
// Top level of the outlier-rejecting ADC filter: controller plus datapath.
// Depends on orf_pkg, orf_ctrl and orf_datapath.
// One burst at a time: the burst is loaded at its transfer, then come the
// squared deviations (one 12x12 multiplier), the square root steps, the
// clip, the divider steps, the smoother update and the output state; the
// next burst is taken in the cycle its predecessor's result transfers.
module outlier_rejecting_adc_filter #(
  parameter int unsigned AXES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  axis_i,
  input  logic [11:0] sample_0_i,
  input  logic [11:0] sample_1_i,
  input  logic [11:0] sample_2_i,
  input  logic [11:0] sample_3_i,
  input  logic [11:0] sample_4_i,
  input  logic [11:0] sample_5_i,
  input  logic [11:0] sample_6_i,
  input  logic [11:0] sample_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  axis_out_o,
  output logic [13:0] smoothed_value_o,
  output logic [11:0] clipped_mean_o
);

  orf_pkg::cmd_t cmd;
  orf_pkg::status_t status;

  orf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  orf_datapath #(.AXES(AXES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .axis_i,
    .samples_i({sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                sample_3_i, sample_2_i, sample_1_i, sample_0_i}),
    .axis_out_o, .smoothed_value_o, .clipped_mean_o
  );

endmodule
